>>> rtl/core/incremental_prime_generator_top_macros.svh
// assertion macros for the incremental prime generator
// used by incremental_prime_generator_top; expects clk and rst_n in scope
`ifndef INCREMENTAL_PRIME_GENERATOR_TOP_MACROS_SVH
`define INCREMENTAL_PRIME_GENERATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IPG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IPG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IPG_ASSERT_IMP(lbl, ante, cons, msg)
`define IPG_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/ipg_pkg.sv
// package for the incremental prime generator: widths, microcode and shared types
// no dependencies
`timescale 1ns / 1ps
package ipg_pkg;

    localparam int NUM_W       = 32;
    localparam int TABLE_DEPTH = 8192;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W     = 16;
    localparam int CAND_W      = NUM_W + 1;
    localparam int DIV_W       = NUM_W / 2 + 2;
    localparam int SQ_W        = 2 * DIV_W;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STEPS   = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int UPC_W       = 5;
    localparam int FIRST_PRIME = 2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_INIT_CAND,
        OP_TEST_INIT,
        OP_LOAD_P,
        OP_SQUARE,
        OP_DIV_START,
        OP_NEXT_I,
        OP_D_FIX,
        OP_P_ADD2,
        OP_C_ADD2,
        OP_STORE,
        OP_SET_FIN,
        OP_EMIT_DONE,
        OP_RESTART
    } dp_op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_RESTART,
        C_FINISHED,
        C_RANGE,
        C_I_END,
        C_SQ_GT,
        C_DIV_BUSY,
        C_REM_ZERO
    } cond_t;

    typedef struct packed {
        dp_op_t           op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic restart_path;
        logic finished;
        logic out_of_range;
        logic i_end;
        logic sq_gt_c;
        logic div_busy;
        logic rem_zero;
    } status_t;

    localparam logic [UPC_W-1:0] S_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] S_DISPATCH  = 5'd1;
    localparam logic [UPC_W-1:0] S_FINCHK    = 5'd2;
    localparam logic [UPC_W-1:0] S_INIT      = 5'd3;
    localparam logic [UPC_W-1:0] S_CHECK     = 5'd4;
    localparam logic [UPC_W-1:0] S_TINIT     = 5'd5;
    localparam logic [UPC_W-1:0] S_TLOOP     = 5'd6;
    localparam logic [UPC_W-1:0] S_TLOAD     = 5'd7;
    localparam logic [UPC_W-1:0] S_TSQ       = 5'd8;
    localparam logic [UPC_W-1:0] S_TCMP      = 5'd9;
    localparam logic [UPC_W-1:0] S_TDIV      = 5'd10;
    localparam logic [UPC_W-1:0] S_TWAIT     = 5'd11;
    localparam logic [UPC_W-1:0] S_TNEXT     = 5'd12;
    localparam logic [UPC_W-1:0] S_TBACK     = 5'd13;
    localparam logic [UPC_W-1:0] S_TAIL      = 5'd14;
    localparam logic [UPC_W-1:0] S_XSQ       = 5'd15;
    localparam logic [UPC_W-1:0] S_XCMP      = 5'd16;
    localparam logic [UPC_W-1:0] S_XDIV      = 5'd17;
    localparam logic [UPC_W-1:0] S_XWAIT     = 5'd18;
    localparam logic [UPC_W-1:0] S_XNEXT     = 5'd19;
    localparam logic [UPC_W-1:0] S_XBACK     = 5'd20;
    localparam logic [UPC_W-1:0] S_COMPOSITE = 5'd21;
    localparam logic [UPC_W-1:0] S_PRIME     = 5'd22;
    localparam logic [UPC_W-1:0] S_SETFIN    = 5'd23;
    localparam logic [UPC_W-1:0] S_DONE      = 5'd24;
    localparam logic [UPC_W-1:0] S_RESTART   = 5'd25;

    function automatic ucode_t ipg_ucode(input logic [UPC_W-1:0] upc);
        ucode_t cw;
        cw = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        unique case (upc)
            S_IDLE:      cw = '{op: OP_ACCEPT,    cond: C_NO_START, target: S_IDLE};
            S_DISPATCH:  cw = '{op: OP_NOP,       cond: C_RESTART,  target: S_RESTART};
            S_FINCHK:    cw = '{op: OP_NOP,       cond: C_FINISHED, target: S_DONE};
            S_INIT:      cw = '{op: OP_INIT_CAND, cond: C_NEVER,    target: S_IDLE};
            S_CHECK:     cw = '{op: OP_NOP,       cond: C_RANGE,    target: S_SETFIN};
            S_TINIT:     cw = '{op: OP_TEST_INIT, cond: C_NEVER,    target: S_IDLE};
            S_TLOOP:     cw = '{op: OP_NOP,       cond: C_I_END,    target: S_TAIL};
            S_TLOAD:     cw = '{op: OP_LOAD_P,    cond: C_NEVER,    target: S_IDLE};
            S_TSQ:       cw = '{op: OP_SQUARE,    cond: C_NEVER,    target: S_IDLE};
            S_TCMP:      cw = '{op: OP_NOP,       cond: C_SQ_GT,    target: S_PRIME};
            S_TDIV:      cw = '{op: OP_DIV_START, cond: C_NEVER,    target: S_IDLE};
            S_TWAIT:     cw = '{op: OP_NOP,       cond: C_DIV_BUSY, target: S_TWAIT};
            S_TNEXT:     cw = '{op: OP_NEXT_I,    cond: C_REM_ZERO, target: S_COMPOSITE};
            S_TBACK:     cw = '{op: OP_NOP,       cond: C_ALWAYS,   target: S_TLOOP};
            S_TAIL:      cw = '{op: OP_D_FIX,     cond: C_NEVER,    target: S_IDLE};
            S_XSQ:       cw = '{op: OP_SQUARE,    cond: C_NEVER,    target: S_IDLE};
            S_XCMP:      cw = '{op: OP_NOP,       cond: C_SQ_GT,    target: S_PRIME};
            S_XDIV:      cw = '{op: OP_DIV_START, cond: C_NEVER,    target: S_IDLE};
            S_XWAIT:     cw = '{op: OP_NOP,       cond: C_DIV_BUSY, target: S_XWAIT};
            S_XNEXT:     cw = '{op: OP_P_ADD2,    cond: C_REM_ZERO, target: S_COMPOSITE};
            S_XBACK:     cw = '{op: OP_NOP,       cond: C_ALWAYS,   target: S_XSQ};
            S_COMPOSITE: cw = '{op: OP_C_ADD2,    cond: C_ALWAYS,   target: S_CHECK};
            S_PRIME:     cw = '{op: OP_STORE,     cond: C_ALWAYS,   target: S_IDLE};
            S_SETFIN:    cw = '{op: OP_SET_FIN,   cond: C_NEVER,    target: S_IDLE};
            S_DONE:      cw = '{op: OP_EMIT_DONE, cond: C_ALWAYS,   target: S_IDLE};
            S_RESTART:   cw = '{op: OP_RESTART,   cond: C_ALWAYS,   target: S_IDLE};
            default:     cw = '{op: OP_NOP,       cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/core/ipg_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ipg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ipg_div.sv
// iterative remainder unit, DIV_BITS quotient bits per cycle
// depends on ipg_pkg
`timescale 1ns / 1ps
module ipg_div
    import ipg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic             rem_zero
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]     sh_reg, sh_next;

    always_comb
    begin
        logic [DIV_W:0]   r;
        logic [NUM_W-1:0] q;
        r = rem_reg;
        q = sh_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r = {r[DIV_W-1:0], q[NUM_W-1]};
            q = {q[NUM_W-2:0], 1'b0};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
        end
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            rem_next = '0;
            sh_next  = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = r;
            sh_next  = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign busy     = (cnt_reg != '0);
    assign rem_zero = (rem_reg == '0);

endmodule

>>> rtl/core/ipg_seq.sv
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on ipg_pkg
`timescale 1ns / 1ps
module ipg_seq
    import ipg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t st,
    output ucode_t  cw,
    output logic    busy
);

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic             take;

    assign cw = ipg_ucode(upc_reg);

    always_comb
    begin
        case (cw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !start;
            C_RESTART:  take = st.restart_path;
            C_FINISHED: take = st.finished;
            C_RANGE:    take = st.out_of_range;
            C_I_END:    take = st.i_end;
            C_SQ_GT:    take = st.sq_gt_c;
            C_DIV_BUSY: take = st.div_busy;
            C_REM_ZERO: take = st.rem_zero;
            default:    take = 1'b0;
        endcase
        upc_next = take ? cw.target : upc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign busy = (upc_reg != S_IDLE);

endmodule

>>> rtl/core/ipg_dp.sv
// datapath: candidate, divisor, counters, limit register and result registers
// depends on ipg_pkg; drives the table ram and the remainder unit
`timescale 1ns / 1ps
module ipg_dp
    import ipg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ucode_t             cw,
    input  logic               restart,
    input  logic               cfg_we,
    input  logic [NUM_W-1:0]   cfg_wdata,
    input  logic [ENTRY_W-1:0] tab_rdata,
    input  logic               div_busy,
    input  logic               div_rem_zero,
    output logic               tab_we,
    output logic [TAB_AW-1:0]  tab_waddr,
    output logic [ENTRY_W-1:0] tab_wdata,
    output logic [TAB_AW-1:0]  tab_raddr,
    output logic               div_start,
    output logic [NUM_W-1:0]   div_dividend,
    output logic [DIV_W-1:0]   div_divisor,
    output status_t            st,
    output logic               res_strobe,
    output logic [NUM_W-1:0]   prime_value,
    output logic [NUM_W-1:0]   prime_ordinal,
    output logic               done_res
);

    // control state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [NUM_W-1:0]  last_reg, last_next;
    logic [NUM_W-1:0]  count_reg, count_next;
    logic              fin_reg, fin_next;
    logic [NUM_W-1:0]  limit_reg, limit_next;
    logic              strobe_reg, strobe_next;
    // working registers
    logic              rst_req_reg, rst_req_next;
    logic [CAND_W-1:0] c_reg, c_next;
    logic [FILL_W-1:0] i_reg, i_next;
    logic [DIV_W-1:0]  d_reg, d_next;
    logic [DIV_W-1:0]  p_reg, p_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [NUM_W-1:0]  val_reg, val_next;
    logic [NUM_W-1:0]  ord_reg, ord_next;
    logic              done_reg, done_next;
    logic              can_store;

    assign can_store = (fill_reg < FILL_W'(TABLE_DEPTH))
                       && (c_reg <= CAND_W'({ENTRY_W{1'b1}}));

    always_comb
    begin
        fill_next    = fill_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        limit_next   = cfg_we ? cfg_wdata : limit_reg;
        strobe_next  = 1'b0;
        rst_req_next = rst_req_reg;
        c_next       = c_reg;
        i_next       = i_reg;
        d_next       = d_reg;
        p_next       = p_reg;
        sq_next      = sq_reg;
        val_next     = val_reg;
        ord_next     = ord_reg;
        done_next    = done_reg;
        tab_we       = 1'b0;
        tab_waddr    = fill_reg[TAB_AW-1:0];
        tab_wdata    = c_reg[ENTRY_W-1:0];
        div_start    = 1'b0;
        case (cw.op)
            OP_ACCEPT:
            begin
                rst_req_next = restart;
            end
            OP_INIT_CAND:
            begin
                c_next = (last_reg == NUM_W'(FIRST_PRIME)) ? CAND_W'(3)
                                                          : {1'b0, last_reg} + CAND_W'(2);
            end
            OP_TEST_INIT:
            begin
                i_next = '0;
                d_next = DIV_W'(3);
            end
            OP_LOAD_P:
            begin
                p_next = DIV_W'(tab_rdata);
            end
            OP_SQUARE:
            begin
                sq_next = p_reg * p_reg;
            end
            OP_DIV_START:
            begin
                div_start = 1'b1;
            end
            OP_NEXT_I:
            begin
                d_next = p_reg + DIV_W'(2);
                i_next = i_reg + 1'b1;
            end
            OP_D_FIX:
            begin
                p_next = d_reg[0] ? d_reg : d_reg + DIV_W'(1);
            end
            OP_P_ADD2:
            begin
                p_next = p_reg + DIV_W'(2);
            end
            OP_C_ADD2:
            begin
                c_next = c_reg + CAND_W'(2);
            end
            OP_STORE:
            begin
                if (can_store)
                begin
                    tab_we    = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                last_next   = c_reg[NUM_W-1:0];
                count_next  = count_reg + 1'b1;
                strobe_next = 1'b1;
                val_next    = c_reg[NUM_W-1:0];
                ord_next    = count_reg + 1'b1;
                done_next   = 1'b0;
            end
            OP_SET_FIN:
            begin
                fin_next = 1'b1;
            end
            OP_EMIT_DONE:
            begin
                strobe_next = 1'b1;
                val_next    = '0;
                ord_next    = count_reg;
                done_next   = 1'b1;
            end
            OP_RESTART:
            begin
                tab_we      = 1'b1;
                tab_waddr   = '0;
                tab_wdata   = ENTRY_W'(FIRST_PRIME);
                fill_next   = FILL_W'(1);
                last_next   = NUM_W'(FIRST_PRIME);
                count_next  = NUM_W'(1);
                fin_next    = 1'b0;
                strobe_next = 1'b1;
                val_next    = NUM_W'(FIRST_PRIME);
                ord_next    = NUM_W'(1);
                done_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            last_reg   <= '0;
            count_reg  <= '0;
            fin_reg    <= 1'b0;
            limit_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
            fin_reg    <= fin_next;
            limit_reg  <= limit_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rst_req_reg <= rst_req_next;
        c_reg       <= c_next;
        i_reg       <= i_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        sq_reg      <= sq_next;
        val_reg     <= val_next;
        ord_reg     <= ord_next;
        done_reg    <= done_next;
    end

    assign tab_raddr    = i_reg[TAB_AW-1:0];
    assign div_dividend = c_reg[NUM_W-1:0];
    assign div_divisor  = p_reg;

    assign st.restart_path = rst_req_reg || (!fin_reg && (last_reg == '0));
    assign st.finished     = fin_reg;
    assign st.out_of_range = c_reg[NUM_W]
                             || ((limit_reg != '0) && (c_reg > {1'b0, limit_reg}));
    assign st.i_end        = (i_reg >= fill_reg);
    assign st.sq_gt_c      = (sq_reg > SQ_W'(c_reg));
    assign st.div_busy     = div_busy;
    assign st.rem_zero     = div_rem_zero;

    assign res_strobe    = strobe_reg;
    assign prime_value   = val_reg;
    assign prime_ordinal = ord_reg;
    assign done_res      = done_reg;

endmodule

>>> rtl/core/incremental_prime_generator_top.sv
// restart answer: dispatch and restart states follow the accepting edge, then the strobe is registered
// done answer once finished: dispatch, finish check and done states, then the strobe; new prime:
// odd candidates tried by trial division (table read, square, remainder unit) up to the square root; then emitted
// one item at a time: busy falls as the result beat goes out; no output stall
// rst_n is asynchronous: counters, limit and sequencer clear; the prime table is not
// cleared, entries above the fill count are never read, so no clearing pass is needed
`timescale 1ns / 1ps
`include "incremental_prime_generator_top_macros.svh"
module incremental_prime_generator_top
    import ipg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             restart,
    input  logic             cfg_we,
    input  logic [NUM_W-1:0] cfg_wdata,
    output logic             res_strobe,
    output logic [NUM_W-1:0] prime_value,
    output logic [NUM_W-1:0] prime_ordinal,
    output logic             done_res
);

    ucode_t             cw;
    status_t            st;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr;
    logic [ENTRY_W-1:0] tab_wdata;
    logic [TAB_AW-1:0]  tab_raddr;
    logic [ENTRY_W-1:0] tab_rdata;
    logic               div_start;
    logic [NUM_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_busy;
    logic               div_rem_zero;

    ipg_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cw    (cw),
        .busy  (busy)
    );

    ipg_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cw            (cw),
        .restart       (restart),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .tab_rdata     (tab_rdata),
        .div_busy      (div_busy),
        .div_rem_zero  (div_rem_zero),
        .tab_we        (tab_we),
        .tab_waddr     (tab_waddr),
        .tab_wdata     (tab_wdata),
        .tab_raddr     (tab_raddr),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .st            (st),
        .res_strobe    (res_strobe),
        .prime_value   (prime_value),
        .prime_ordinal (prime_ordinal),
        .done_res      (done_res)
    );

    ipg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    ipg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .rem_zero (div_rem_zero)
    );

    `IPG_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `IPG_ASSERT_IMP(a_done_zero, res_strobe && done_res, prime_value == '0, "done beat with value")
    `IPG_ASSERT_IMP(a_prime_odd, res_strobe && !done_res,
        prime_value[0] || (prime_value == NUM_W'(FIRST_PRIME)), "even prime other than two")
    `IPG_ASSERT_IMP(a_ord_nonzero, res_strobe && !done_res, prime_ordinal != '0,
        "prime beat with zero ordinal")

endmodule
